>>> rtl/ssid_pkg.sv
package ssid_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 5;
  // cells per first-level group of the registered OR trees
  localparam int unsigned Group  = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                   shift_up;
    logic                   shift_dn;
    logic signed [KeyW-1:0] key;
  } cell_ctrl_t;

endpackage

>>> rtl/ssid_if.sv
interface ssid_in_if;
  import ssid_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic signed [KeyW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ssid_out_if;
  import ssid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatW-1:0]         status;
  logic [CountW-1:0]        entry_count;
  logic                     is_empty;
  logic signed [KeyW-1:0]   smallest;
  logic signed [KeyW-1:0]   largest;

  modport source (output valid, output status, output entry_count, output is_empty,
                  output smallest, output largest, input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  input smallest, input largest, output ready);
endinterface

>>> rtl/ssid_cell.sv
module ssid_cell import ssid_pkg::*; (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic                   valid_i,
  input  logic                   left_lt_i,
  input  logic signed [KeyW-1:0] left_entry_i,
  input  logic signed [KeyW-1:0] right_entry_i,
  output logic signed [KeyW-1:0] entry_o,
  output logic                   lt_o,
  output logic                   eq_o
);

  logic signed [KeyW-1:0] entry_q, entry_d;
  logic                   lt_q, eq_q;

  // insert: below the key: hold; first place not below: take key;
  // above that: take the left neighbour's word; delete: not below: take the right one
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_up && !lt_q) begin
      entry_d = left_lt_i ? ctrl_i.key : left_entry_i;
    end else if (ctrl_i.shift_dn && !lt_q) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lt_q    <= valid_i && ($signed(entry_q) < $signed(ctrl_i.key));
    eq_q    <= valid_i && (entry_q == ctrl_i.key);
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

>>> rtl/ssid_or_red.sv
module ssid_or_red import ssid_pkg::*; #(
  parameter int unsigned N = 16,
  parameter int unsigned W = 1
) (
  input  logic                  clk_i,
  input  logic [N-1:0][W-1:0]   d_i,
  output logic [W-1:0]          q_o
);

  localparam int unsigned NGrp = (N + Group - 1) / Group;

  logic [NGrp-1:0][W-1:0] grp_d, grp_q;
  logic [W-1:0]           all_d, all_q;

  always_comb begin
    for (int unsigned g = 0; g < NGrp; g++) begin
      grp_d[g] = '0;
      for (int unsigned k = 0; k < Group; k++) begin
        if (g * Group + k < N) begin
          grp_d[g] = grp_d[g] | d_i[g * Group + k];
        end
      end
    end
  end

  always_comb begin
    all_d = '0;
    for (int unsigned g = 0; g < NGrp; g++) begin
      all_d = all_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    all_q <= all_d;
  end

  assign q_o = all_q;

endmodule

>>> rtl/sorted_set_insert_delete_top.sv
// Sorted set engine: holds up to DEPTH distinct signed 32-bit keys in ascending order in
// a row of cells, one key per cell. A word with cmd insert places the key at its sorted
// place (status inserted), or reports duplicate if it is already held, or full if the row
// is full; cmd delete removes the key (deleted) or reports not found. Each word in gives
// exactly one word out with the count, an empty flag and the least and greatest key
// (both 0 when empty). Every cell compares its key with the broadcast key in parallel;
// the hit is collected by a two-level registered OR tree, then the row shifts up or down
// by one place, and the greatest key is collected by a second OR tree.
// An item passes the states S_CMP, S_FND1, S_FND2 (hit tree), S_UPD, S_MAX1, S_MAX2 (max
// tree) and S_OUT; in_i.ready is high only between items, while a finished result may
// still wait in the output register. No clearing pass is needed after reset.
module sorted_set_insert_delete_top import ssid_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssid_in_if.sink     in_i,
  ssid_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_FND1, S_FND2, S_UPD, S_MAX1, S_MAX2, S_OUT
  } state_e;

  state_e                  state_q;
  logic                    cmd_q;
  logic signed [KeyW-1:0]  key_q;
  logic [CntW-1:0]         count_q;
  status_e                 status_q;

  logic                    out_valid_q;
  logic [StatW-1:0]        out_status_q;
  logic [CountW-1:0]       out_count_q;
  logic                    out_empty_q;
  logic signed [KeyW-1:0]  out_small_q;
  logic signed [KeyW-1:0]  out_large_q;

  // row of cells
  cell_ctrl_t                          ctrl;
  logic signed [KeyW-1:0]              entry_w [DEPTH];
  logic [DEPTH-1:0]                    lt_w, eq_w, valid_w, last_w;
  logic [DEPTH-1:0][0:0]               hit_in;
  logic [DEPTH-1:0][KeyW-1:0]          max_in;
  logic [0:0]                          found;
  logic [KeyW-1:0]                     largest;

  logic                                full;
  logic                                ins_ok, del_ok;
  logic [CntW+CountW-1:0]              count_wide;

  assign full   = (count_q == CntW'(DEPTH));
  assign ins_ok = (state_q == S_UPD) && (cmd_q == CMD_INSERT) && !found[0] && !full;
  assign del_ok = (state_q == S_UPD) && (cmd_q == CMD_DELETE) && found[0];

  assign ctrl.shift_up = ins_ok;
  assign ctrl.shift_dn = del_ok;
  assign ctrl.key      = key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   left_lt;
    logic signed [KeyW-1:0] left_entry, right_entry;

    assign valid_w[i] = (CntW'(i) < count_q);
    // the top occupied cell (index count - 1) holds the greatest key
    assign last_w[i]  = (CntW'(i + 1) == count_q);
    assign hit_in[i]  = eq_w[i];
    assign max_in[i]  = last_w[i] ? entry_w[i] : '0;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = key_q;
    end else begin : g_mid
      assign left_lt    = lt_w[i-1];
      assign left_entry = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
    end

    ssid_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (valid_w[i]),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .lt_o          (lt_w[i]),
      .eq_o          (eq_w[i])
    );
  end

  ssid_or_red #(.N(DEPTH), .W(1)) u_hit_red (
    .clk_i (clk_i),
    .d_i   (hit_in),
    .q_o   (found)
  );

  ssid_or_red #(.N(DEPTH), .W(KeyW)) u_max_red (
    .clk_i (clk_i),
    .d_i   (max_in),
    .q_o   (largest)
  );

  assign count_wide = {{CountW{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_INSERT;
      key_q        <= '0;
      count_q      <= '0;
      status_q     <= ST_INSERTED;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_count_q  <= '0;
      out_empty_q  <= 1'b0;
      out_small_q  <= '0;
      out_large_q  <= '0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q   <= in_i.cmd;
            key_q   <= in_i.value;
            state_q <= S_CMP;
          end
        end
        S_CMP:  state_q <= S_FND1;
        S_FND1: state_q <= S_FND2;
        S_FND2: state_q <= S_UPD;
        S_UPD: begin
          if (cmd_q == CMD_INSERT) begin
            if (found[0]) begin
              status_q <= ST_DUPLICATE;
            end else if (full) begin
              status_q <= ST_FULL;
            end else begin
              status_q <= ST_INSERTED;
              count_q  <= count_q + 1'b1;
            end
          end else begin
            if (found[0]) begin
              status_q <= ST_DELETED;
              count_q  <= count_q - 1'b1;
            end else begin
              status_q <= ST_NOT_FOUND;
            end
          end
          state_q <= S_MAX1;
        end
        S_MAX1: state_q <= S_MAX2;
        S_MAX2: state_q <= S_OUT;
        S_OUT: begin
          // wait for the previous result to leave
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_count_q  <= count_wide[CountW-1:0];
            out_empty_q  <= (count_q == '0);
            out_small_q  <= (count_q == '0) ? '0 : entry_w[0];
            out_large_q  <= largest;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.smallest    = out_small_q;
  assign out_o.largest     = out_large_q;

  // count never runs past the row
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond row depth");

  // an accepted insert grows the count by one
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow count");

  // a full rejection only happens with the row full
  a_full_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAX1 && status_q == ST_FULL) |-> full)
    else $error("full status with free cells");

  // an empty result carries zero bounds
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_small_q == '0 && out_large_q == '0))
    else $error("empty result with non-zero bounds");

endmodule

>>> test/tb_top.sv
module tb_top;
  import ssid_pkg::*;

  localparam int unsigned DEPTH      = 16;
  // Quiet time after the last result before judging.
  localparam int unsigned SETTLE     = 16;
  localparam int unsigned RAND_WORDS = 1550;
  localparam int unsigned SEG_WORDS  = 50;
  localparam int unsigned POOL_N     = 20;
  localparam int unsigned HOLD_LEN   = 200;
  // Slowest run: ~1600 words x (block pass + long sender gap + long receiver
  // stall) plus two long hold-offs, then several times over.
  localparam int unsigned LIMIT      = 400_000;

  // One result word as the block reports it.
  typedef struct packed {
    status_e                status;
    logic [CountW-1:0]      entry_count;
    logic                   is_empty;
    logic signed [KeyW-1:0] smallest;
    logic signed [KeyW-1:0] largest;
  } outcome_t;

  // Keeps its own ascending copy of the set, works out the outcome of each
  // accepted word and checks the block's result words against them in order.
  class sorted_set_book;
    logic signed [KeyW-1:0] keys_held[$];
    outcome_t               outcomes_due[$];
    int unsigned            errors;
    int unsigned            words_in;
    int unsigned            words_out;
    int unsigned            status_seen[8];
    int unsigned            peak_count;

    function void note_word(cmd_e op, logic signed [KeyW-1:0] key);
      outcome_t    want;
      int unsigned pos;
      bit          hit;
      pos = 0;
      while (pos < keys_held.size() && keys_held[pos] < key) pos++;
      hit = (pos < keys_held.size()) && (keys_held[pos] == key);
      if (op == CMD_INSERT) begin
        if (hit) begin
          want.status = ST_DUPLICATE;
        end else if (keys_held.size() >= DEPTH) begin
          want.status = ST_FULL;
        end else begin
          keys_held.insert(pos, key);
          want.status = ST_INSERTED;
        end
      end else begin
        if (hit) begin
          keys_held.delete(pos);
          want.status = ST_DELETED;
        end else begin
          want.status = ST_NOT_FOUND;
        end
      end
      want.entry_count = CountW'(keys_held.size());
      want.is_empty    = (keys_held.size() == 0);
      want.smallest    = (keys_held.size() == 0) ? '0 : keys_held[0];
      want.largest     = (keys_held.size() == 0) ? '0 : keys_held[keys_held.size() - 1];
      if (keys_held.size() > peak_count) peak_count = keys_held.size();
      status_seen[want.status]++;
      words_in++;
      outcomes_due.push_back(want);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      words_out++;
      if (outcomes_due.size() == 0) begin
        $error("result word with nothing outstanding: status %0d count %0d",
               got.status, got.entry_count);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.smallest !== want.smallest) begin
        $error("smallest: expected %0d, got %0d", want.smallest, got.smallest);
        errors++;
      end
      if (got.largest !== want.largest) begin
        $error("largest: expected %0d, got %0d", want.largest, got.largest);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ssid_in_if  in_if ();
  ssid_out_if out_if ();

  sorted_set_insert_delete_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  sorted_set_book         book;
  bit                     calm;     // no idling on either side while set
  bit                     hold_req; // asks the receiver for a long hold-off
  logic signed [KeyW-1:0] key_pool[POOL_N];
  int unsigned            cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog: a hang anywhere ends up here.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  // Receiver: random back-pressure, plus the long hold-off on request,
  // counted here so the sender keeps offering words meanwhile.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // Result monitor: sample at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status      = status_e'(out_if.status);
      got.entry_count = out_if.entry_count;
      got.is_empty    = out_if.is_empty;
      got.smallest    = out_if.smallest;
      got.largest     = out_if.largest;
      book.check_outcome(got);
    end
  end

  // Sender idles about a third of the time, unless in a calm stretch.
  // Called at a falling edge; valid is only dropped on an idle cycle so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic sender_gap();
    while (!calm && $urandom_range(99) < 34) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Offer one word and hold it until the block takes it; returns at the
  // following falling edge.
  task automatic send_word(cmd_e op, logic signed [KeyW-1:0] key);
    in_if.valid <= 1'b1;
    in_if.cmd   <= op;
    in_if.value <= key;
    do @(posedge clk_i); while (!in_if.ready);
    book.note_word(op, key);
    @(negedge clk_i);
  endtask

  // Stop offering until every outstanding result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (book.outcomes_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Fresh key pool per segment: small enough that keys collide, so
  // duplicates, hits on delete and a full row all happen often.
  task automatic refill_pool();
    for (int i = 0; i < POOL_N; i++) begin
      case ($urandom_range(3))
        0:       key_pool[i] = $urandom;
        1:       key_pool[i] = $signed($urandom_range(40)) - 20;
        2:       key_pool[i] = 32'h8000_0000 + $urandom_range(3);
        default: key_pool[i] = 32'h7fff_ffff - $urandom_range(3);
      endcase
    end
  endtask

  initial begin
    int unsigned            sent;
    int unsigned            seg;
    int unsigned            ins_pct;
    int unsigned            guard;
    cmd_e                   op;
    logic signed [KeyW-1:0] key;

    book        = new();
    calm        = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_INSERT;
    in_if.value = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: delete from an empty set, the key extremes, a duplicate, a
    // miss on delete, filling the row, a new key into the full row, a duplicate
    // into the full row, deletes at both ends and in the middle, then one insert.
    send_word(CMD_DELETE, 32'sd0);
    send_word(CMD_INSERT, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sh8000_0000);
    send_word(CMD_INSERT, 32'sh8000_0000);
    send_word(CMD_DELETE, 32'sd5);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sd1);
    for (int i = 2; i < 13; i++) begin
      sender_gap();
      send_word(CMD_INSERT, (i % 2) ? i * 1000003 : -i * 1000003);
    end
    send_word(CMD_INSERT, 32'sd12345);      // row full: rejected
    send_word(CMD_INSERT, 32'sh7fff_ffff);  // full, but a duplicate
    send_word(CMD_DELETE, 32'sh8000_0000);
    send_word(CMD_DELETE, 32'sh7fff_ffff);
    send_word(CMD_DELETE, 32'sd0);
    send_word(CMD_INSERT, 32'sh5555_5555);
    drain_results();

    // Random: segments that mostly fill, mostly empty, or balance the set,
    // with a tenth of keys fresh from the full range as noise.
    sent = 0;
    seg  = 0;
    while (sent < RAND_WORDS) begin
      refill_pool();
      case (seg % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      calm = (seg == 12 || seg == 13);
      if (seg == 5 || seg == 20) hold_req = 1'b1;
      for (int k = 0; k < SEG_WORDS; k++) begin
        sender_gap();
        op  = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_N - 1)];
        send_word(op, key);
        sent++;
      end
      if (seg % 7 == 6) drain_results();
      seg++;
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    guard = 0;
    while (book.outcomes_due.size() != 0 && guard < 20 * HOLD_LEN) begin
      @(posedge clk_i);
      guard++;
    end
    if (book.outcomes_due.size() != 0) begin
      $error("%0d results never arrived", book.outcomes_due.size());
      book.errors++;
    end
    repeat (SETTLE) @(posedge clk_i);

    $display("%0d words in, %0d results out, peak %0d keys held, %0d cycles",
             book.words_in, book.words_out, book.peak_count, cycles);
    $display("inserted %0d, duplicate %0d, deleted %0d, not found %0d, full %0d",
             book.status_seen[ST_INSERTED], book.status_seen[ST_DUPLICATE],
             book.status_seen[ST_DELETED], book.status_seen[ST_NOT_FOUND],
             book.status_seen[ST_FULL]);
    if (book.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
